// ----- design/stcp_pkg.sv -----
// shared types, constants and helpers of the serial text command parser
package stcp_pkg;

  localparam int unsigned LINE_BYTES = 64;
  localparam int unsigned LEN_W      = $clog2(LINE_BYTES + 1);
  localparam int unsigned NAME_CHARS = 12;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_INFO     = 3'd1,
    KIND_SEND     = 3'd2,
    KIND_RESET    = 3'd3,
    KIND_QUERY    = 3'd4,
    KIND_MODE     = 3'd5,
    KIND_SELECT   = 3'd6,
    KIND_GENERATE = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    ST_COLLECT = 3'b001,
    ST_OVF     = 3'b010,
    ST_PEND    = 3'b100
  } state_e;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd126;

  // command texts, left aligned in 16 characters
  localparam int unsigned NUM_CMDS   = 7;
  localparam int unsigned CMD_INFO   = 0;
  localparam int unsigned CMD_SEND   = 1;
  localparam int unsigned CMD_RESET  = 2;
  localparam int unsigned CMD_RATE   = 3;
  localparam int unsigned CMD_WAV    = 4;
  localparam int unsigned CMD_TX     = 5;
  localparam int unsigned CMD_STATUS = 6;

  localparam logic [127:0] CMD_TEXT [NUM_CMDS] = '{
    {"CMD:MODEM INFO:?"},
    {"CMD:SENDBUFFER", 16'h0},
    {"CMD:RESET MDM", 24'h0},
    {"CMD:DATA RATE:", 16'h0},
    {"CMD:WAV FILE:", 24'h0},
    {"CMD:TX FILE:", 32'h0},
    {"CMD:STATUS:?", 32'h0}
  };
  localparam logic [4:0] CMD_LEN [NUM_CMDS] = '{
    5'd16, 5'd14, 5'd13, 5'd14, 5'd13, 5'd12, 5'd12
  };
  // commands matched as a prefix of the line
  localparam logic [NUM_CMDS-1:0] CMD_PREFIX = 7'b0111000;

  // data rate tokens, left aligned in 5 characters; the last one is the query
  localparam int unsigned NUM_TOKENS = 14;
  localparam int unsigned TOK_QUERY  = 13;
  localparam logic [39:0] TOK_TEXT [NUM_TOKENS] = '{
    {"75S", 16'h0}, {"75L", 16'h0}, {"150S", 8'h0}, {"150L", 8'h0},
    {"300S", 8'h0}, {"300L", 8'h0}, {"600S", 8'h0}, {"600L", 8'h0},
    {"1200S"}, {"1200L"}, {"2400S"}, {"2400L"}, {"4800U"}, {"?", 32'h0}
  };
  localparam logic [2:0] TOK_LEN [NUM_TOKENS] = '{
    3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd1
  };
  localparam logic [12:0] TOK_RATE [NUM_TOKENS] = '{
    13'd75, 13'd75, 13'd150, 13'd150, 13'd300, 13'd300, 13'd600, 13'd600,
    13'd1200, 13'd1200, 13'd2400, 13'd2400, 13'd4800, 13'd0
  };
  localparam logic [1:0] TOK_ILV [NUM_TOKENS] = '{
    2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1,
    2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd0
  };

  localparam logic [23:0] EXT_WAV = "WAV";
  localparam logic [23:0] EXT_BIN = "BIN";

  typedef struct packed {
    kind_e       kind;
    logic        valid_res;
    logic        rate_query;
    logic [12:0] data_rate;
    logic [1:0]  interleave;
    logic [63:0] wav_name_head;
    logic [31:0] wav_name_tail;
    logic [63:0] source_name_head;
    logic [31:0] source_name_tail;
  } result_t;

  typedef struct packed {
    logic clear;
    logic store;
    logic emit_byte;
    logic emit_term;
    logic emit_blank;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_term;
    logic printable;
    logic line_full;
    logic line_empty;
    logic byte_hit;
    logic out_valid;
  } dp_status_t;

  function automatic logic is_name_char(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") || c == CH_UNDER;
  endfunction

endpackage

// ----- design/stcp_if.sv -----
// transaction channels of the serial text command parser
interface stcp_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] byte_value;
  modport source (output valid, req_type, byte_value, input ready);
  modport sink (input valid, req_type, byte_value, output ready);
endinterface

interface stcp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic        valid_res;
  logic        rate_query;
  logic [12:0] data_rate;
  logic [1:0]  interleave;
  logic [63:0] wav_name_head;
  logic [31:0] wav_name_tail;
  logic [63:0] source_name_head;
  logic [31:0] source_name_tail;
  modport source (output valid, kind, valid_res, rate_query, data_rate, interleave,
                  wav_name_head, wav_name_tail, source_name_head, source_name_tail,
                  input ready);
  modport sink (input valid, kind, valid_res, rate_query, data_rate, interleave,
                wav_name_head, wav_name_tail, source_name_head, source_name_tail,
                output ready);
endinterface

// ----- design/stcp_name_chk.sv -----
// incremental file name checker and packer
module stcp_name_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        clear_i,
  input  logic        en_i,
  input  logic [7:0]  char_i,
  input  logic [23:0] ext_i,
  output logic        ok_o,
  output logic [95:0] name_o
);
  import stcp_pkg::*;

  logic [3:0]  cnt_q, cnt_d;
  logic [3:0]  stem_q, stem_d;
  logic [1:0]  ext_q, ext_d;
  logic        dot_q, dot_d;
  logic        bad_q, bad_d;
  logic [95:0] name_q, name_d;

  always_comb begin
    cnt_d  = cnt_q;
    stem_d = stem_q;
    ext_d  = ext_q;
    dot_d  = dot_q;
    bad_d  = bad_q;
    name_d = name_q;
    if (en_i) begin
      if (cnt_q == 4'(NAME_CHARS)) begin
        bad_d = 1'b1;
      end else begin
        name_d[8*(4'(NAME_CHARS - 1) - cnt_q) +: 8] = char_i;
        cnt_d = cnt_q + 4'd1;
      end
      if (!dot_q) begin
        if (char_i == CH_DOT) begin
          if (stem_q == 4'd0) bad_d = 1'b1;
          else dot_d = 1'b1;
        end else if (is_name_char(char_i) && stem_q < 4'd8) begin
          stem_d = stem_q + 4'd1;
        end else begin
          bad_d = 1'b1;
        end
      end else if (ext_q != 2'd3 && char_i == ext_i[8*(2'd2 - ext_q) +: 8]) begin
        ext_d = ext_q + 2'd1;
      end else begin
        bad_d = 1'b1;
      end
    end
    if (clear_i) begin
      cnt_d  = '0;
      stem_d = '0;
      ext_d  = '0;
      dot_d  = 1'b0;
      bad_d  = 1'b0;
      name_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      stem_q <= '0;
      ext_q  <= '0;
      dot_q  <= 1'b0;
      bad_q  <= 1'b0;
      name_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      stem_q <= stem_d;
      ext_q  <= ext_d;
      dot_q  <= dot_d;
      bad_q  <= bad_d;
      name_q <= name_d;
    end
  end

  assign ok_o   = !bad_q && dot_q && ext_q == 2'd3;
  assign name_o = name_q;
endmodule

// ----- design/stcp_datapath.sv -----
// line matchers, name checkers and result register
module stcp_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  stcp_pkg::ctrl_cmd_t    cmd_i,
  input  logic [7:0]             byte_i,
  input  logic                   out_ready_i,
  output stcp_pkg::dp_status_t   status_o,
  output stcp_pkg::result_t      result_o
);
  import stcp_pkg::*;

  logic [LEN_W-1:0]      len_q, len_d, len_inc, arg_off;
  logic [NUM_CMDS-1:0]   pm_q, pm_d;
  logic [NUM_TOKENS-1:0] tok_q, tok_d;
  logic                  colon_q, colon_d;
  logic                  out_valid_q;
  result_t               res_q, res_byte, res_term;
  logic                  byte_hit, rate_new, at_arg;
  logic                  wf_ok, bin_ok, txw_ok;
  logic [95:0]           wf_name, bin_name, txw_name;
  logic                  tx_ok;

  assign len_inc = len_q + 1'b1;
  assign arg_off = len_q - LEN_W'(CMD_LEN[CMD_RATE]);
  assign at_arg  = len_q >= LEN_W'(CMD_LEN[CMD_RATE]);

  // prefix and token match flags as the byte is appended
  always_comb begin
    for (int k = 0; k < NUM_CMDS; k++) begin
      if (len_q < LEN_W'(CMD_LEN[k]))
        pm_d[k] = pm_q[k] && byte_i == CMD_TEXT[k][8*(4'd15 - len_q[3:0]) +: 8];
      else
        pm_d[k] = pm_q[k] && CMD_PREFIX[k];
    end
    for (int t = 0; t < NUM_TOKENS; t++) begin
      if (!at_arg)
        tok_d[t] = tok_q[t];
      else
        tok_d[t] = tok_q[t] && arg_off < LEN_W'(TOK_LEN[t]) &&
                   byte_i == TOK_TEXT[t][8*(3'd4 - arg_off[2:0]) +: 8];
    end
  end

  assign rate_new = pm_d[CMD_RATE] && len_inc >= LEN_W'(CMD_LEN[CMD_RATE]);

  // result of the line that now ends with this byte
  always_comb begin
    res_byte = '0;
    byte_hit = 1'b0;
    if (pm_d[CMD_INFO] && len_inc == LEN_W'(CMD_LEN[CMD_INFO])) begin
      res_byte.kind = KIND_INFO;
      byte_hit = 1'b1;
    end else if (pm_d[CMD_SEND] && len_inc == LEN_W'(CMD_LEN[CMD_SEND])) begin
      res_byte.kind = KIND_SEND;
      byte_hit = 1'b1;
    end else if (pm_d[CMD_RESET] && len_inc == LEN_W'(CMD_LEN[CMD_RESET])) begin
      res_byte.kind = KIND_RESET;
      byte_hit = 1'b1;
    end else if (rate_new) begin
      for (int t = 0; t < NUM_TOKENS; t++) begin
        if (tok_d[t] && len_inc - LEN_W'(CMD_LEN[CMD_RATE]) == LEN_W'(TOK_LEN[t])) begin
          byte_hit = 1'b1;
          if (t == TOK_QUERY) begin
            res_byte.kind       = KIND_QUERY;
            res_byte.rate_query = 1'b1;
          end else begin
            res_byte.kind       = KIND_MODE;
            res_byte.data_rate  = TOK_RATE[t];
            res_byte.interleave = TOK_ILV[t];
          end
        end
      end
    end
    res_byte.valid_res = byte_hit;
  end

  assign tx_ok = colon_q && bin_ok && txw_ok;

  // result at a line terminator
  always_comb begin
    res_term = '0;
    if (pm_q[CMD_RATE] && len_q >= LEN_W'(CMD_LEN[CMD_RATE])) begin
      res_term.kind = KIND_NONE;
    end else if (pm_q[CMD_WAV] && len_q >= LEN_W'(CMD_LEN[CMD_WAV])) begin
      res_term.kind      = KIND_SELECT;
      res_term.valid_res = wf_ok;
      if (wf_ok) {res_term.wav_name_head, res_term.wav_name_tail} = wf_name;
    end else if (pm_q[CMD_TX] && len_q >= LEN_W'(CMD_LEN[CMD_TX])) begin
      res_term.kind      = KIND_GENERATE;
      res_term.valid_res = tx_ok;
      if (colon_q && bin_ok)
        {res_term.source_name_head, res_term.source_name_tail} = bin_name;
      if (tx_ok) {res_term.wav_name_head, res_term.wav_name_tail} = txw_name;
    end else if (pm_q[CMD_STATUS] && len_q == LEN_W'(CMD_LEN[CMD_STATUS])) begin
      res_term.kind      = KIND_QUERY;
      res_term.valid_res = 1'b1;
    end
  end

  stcp_name_chk u_wav_file (
    .clk_i, .rst_ni,
    .clear_i(cmd_i.clear),
    .en_i(cmd_i.store && len_q >= LEN_W'(CMD_LEN[CMD_WAV])),
    .char_i(byte_i), .ext_i(EXT_WAV), .ok_o(wf_ok), .name_o(wf_name)
  );

  stcp_name_chk u_tx_bin (
    .clk_i, .rst_ni,
    .clear_i(cmd_i.clear),
    .en_i(cmd_i.store && len_q >= LEN_W'(CMD_LEN[CMD_TX]) && !colon_q && byte_i != CH_COLON),
    .char_i(byte_i), .ext_i(EXT_BIN), .ok_o(bin_ok), .name_o(bin_name)
  );

  stcp_name_chk u_tx_wav (
    .clk_i, .rst_ni,
    .clear_i(cmd_i.clear),
    .en_i(cmd_i.store && colon_q),
    .char_i(byte_i), .ext_i(EXT_WAV), .ok_o(txw_ok), .name_o(txw_name)
  );

  always_comb begin
    len_d   = len_q;
    colon_d = colon_q;
    if (cmd_i.clear) begin
      len_d   = '0;
      colon_d = 1'b0;
    end else if (cmd_i.store) begin
      len_d   = len_inc;
      colon_d = colon_q || (len_q >= LEN_W'(CMD_LEN[CMD_TX]) && byte_i == CH_COLON);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      pm_q        <= '1;
      tok_q       <= '1;
      colon_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q   <= len_d;
      colon_q <= colon_d;
      if (cmd_i.clear) begin
        pm_q  <= '1;
        tok_q <= '1;
      end else if (cmd_i.store) begin
        pm_q  <= pm_d;
        tok_q <= tok_d;
      end
      if (cmd_i.emit_byte || cmd_i.emit_term || cmd_i.emit_blank) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_byte) res_q <= res_byte;
    else if (cmd_i.emit_term) res_q <= res_term;
    else if (cmd_i.emit_blank) res_q <= '0;
  end

  always_comb begin
    status_o.is_term    = byte_i == CH_CR || byte_i == CH_LF;
    status_o.printable  = byte_i inside {[PRINT_LO:PRINT_HI]};
    status_o.line_full  = len_q >= LEN_W'(LINE_BYTES - 1);
    status_o.line_empty = len_q == '0;
    status_o.byte_hit   = byte_hit;
    status_o.out_valid  = out_valid_q;
  end

  assign result_o = res_q;
endmodule

// ----- design/stcp_ctrl.sv -----
// parser controller state machine
module stcp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 req_type_i,
  input  logic                 out_ready_i,
  input  stcp_pkg::dp_status_t status_i,
  output logic                 in_ready_o,
  output stcp_pkg::ctrl_cmd_t  cmd_o
);
  import stcp_pkg::*;

  state_e state_q, state_d;
  logic   fire;

  // bytes while a result is held are dropped, so they never need the output slot
  assign in_ready_o = !status_i.out_valid || out_ready_i || state_q == ST_PEND;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    if (fire) begin
      if (req_type_i) begin
        cmd_o.clear = 1'b1;
        state_d     = ST_COLLECT;
      end else begin
        case (state_q)
          ST_PEND: ;
          ST_OVF: begin
            if (status_i.is_term) begin
              cmd_o.emit_blank = 1'b1;
              state_d          = ST_PEND;
            end
          end
          ST_COLLECT: begin
            if (status_i.is_term) begin
              if (!status_i.line_empty) begin
                cmd_o.emit_term = 1'b1;
                state_d         = ST_PEND;
              end
            end else if (status_i.line_full || !status_i.printable) begin
              state_d = ST_OVF;
            end else begin
              cmd_o.store = 1'b1;
              if (status_i.byte_hit) begin
                cmd_o.emit_byte = 1'b1;
                state_d         = ST_PEND;
              end
            end
          end
          default: state_d = ST_COLLECT;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_COLLECT;
    else state_q <= state_d;
  end
endmodule

// ----- design/serial_text_command_parser.sv -----
// Serial text command parser: each transaction on in_i is one received byte (req_type 0) or a
// consume (req_type 1); the line is matched as it arrives by per command prefix flags, data
// rate token flags and three incremental file name checkers, so no scan is needed at CR or LF.
// Info, send, reset and data rate commands give their result on their last character, the
// others on the terminator. One result at most is held in the output register; until a
// consume arrives further bytes are taken and dropped, and a new transaction is refused only
// while the output register is full and the parser could still produce a result.
module serial_text_command_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  stcp_in_if.sink    in_i,
  stcp_out_if.source out_o
);
  import stcp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  result_t    res;

  stcp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid),
    .req_type_i(in_i.req_type),
    .out_ready_i(out_o.ready),
    .status_i(status),
    .in_ready_o(in_i.ready),
    .cmd_o(cmd)
  );

  stcp_datapath u_datapath (
    .clk_i, .rst_ni,
    .cmd_i(cmd),
    .byte_i(in_i.byte_value),
    .out_ready_i(out_o.ready),
    .status_o(status),
    .result_o(res)
  );

  assign out_o.valid            = status.out_valid;
  assign out_o.kind             = res.kind;
  assign out_o.valid_res        = res.valid_res;
  assign out_o.rate_query       = res.rate_query;
  assign out_o.data_rate        = res.data_rate;
  assign out_o.interleave       = res.interleave;
  assign out_o.wav_name_head    = res.wav_name_head;
  assign out_o.wav_name_tail    = res.wav_name_tail;
  assign out_o.source_name_head = res.source_name_head;
  assign out_o.source_name_tail = res.source_name_tail;
endmodule

// ----- design/stcp_checker.sv -----
// port level checks of the serial text command parser and their binding
module stcp_port_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  kind_i,
  input logic        valid_res_i,
  input logic        rate_query_i,
  input logic [12:0] data_rate_i
);
  import stcp_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) && $stable(data_rate_i))
    else $error("result changed while stalled");

  a_none_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == KIND_NONE |-> !valid_res_i)
    else $error("unknown line reported as valid");

  a_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && rate_query_i |-> kind_i == KIND_QUERY && valid_res_i)
    else $error("rate query flag on wrong kind");

  a_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && data_rate_i != 13'd0 |-> kind_i == KIND_MODE)
    else $error("data rate on wrong kind");
endmodule

bind serial_text_command_parser stcp_port_props u_stcp_port_props (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .kind_i(out_o.kind),
  .valid_res_i(out_o.valid_res),
  .rate_query_i(out_o.rate_query),
  .data_rate_i(out_o.data_rate)
);
